// ----- src/rcre_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rcre_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CHAN_W   = 2;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	// register index in the APB map (byte address = 4 * index)
	localparam logic [0:0] REG_MAX_RUN = 1'b0;
	localparam logic [BYTE_W-1:0] MAX_RUN_RESET = 8'd255;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [BYTE_W-1:0] run_length;
		logic [BYTE_W-1:0] run_byte;
		logic              final_run;
		logic              last_of_item;
	} pair_t;

	// what one lane found for the current pixel
	typedef struct packed {
		logic              brk_valid;
		logic [BYTE_W-1:0] brk_len;
		logic [BYTE_W-1:0] brk_byte;
		logic [BYTE_W-1:0] fin_len;
		logic [BYTE_W-1:0] fin_byte;
	} lane_pairs_t;

endpackage
`default_nettype wire

// ----- src/rcre_pixel_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rcre_pixel_if import rcre_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/rcre_pair_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rcre_pair_if import rcre_pkg::*; ();
	logic  valid;
	logic  ready;
	pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/rcre_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rcre_lane import rcre_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [BYTE_W-1:0] pixel_byte,
	input  wire logic              last_pixel,
	input  wire logic              run_open,
	input  wire logic [BYTE_W-1:0] max_run,
	output lane_pairs_t            pairs
);
	logic [BYTE_W-1:0] run_value_q;
	logic [BYTE_W-1:0] run_count_q;
	logic              brk;
	logic [BYTE_W-1:0] next_count;

	assign brk = run_open && ((pixel_byte != run_value_q) || (run_count_q >= max_run));
	assign next_count = (!run_open || brk) ? BYTE_W'(1) : run_count_q + BYTE_W'(1);

	always_comb begin
		pairs.brk_valid = brk;
		pairs.brk_len   = run_count_q;
		pairs.brk_byte  = run_value_q;
		pairs.fin_len   = next_count;
		pairs.fin_byte  = pixel_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q <= '0;
			run_count_q <= '0;
		end else if (accept) begin
			// frame end closes every run
			if (last_pixel) begin
				run_value_q <= '0;
				run_count_q <= '0;
			end else begin
				run_value_q <= pixel_byte;
				run_count_q <= next_count;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/rcre_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rcre_merge import rcre_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        last_pixel,
	input  lane_pairs_t      lanes [NUM_CHANNELS],
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output pair_t            out_pair
);
	localparam int unsigned NS    = 2 * NUM_CHANNELS;
	localparam int unsigned IDX_W = $clog2(NS);

	// slot c: pair closed in channel c; slot NUM_CHANNELS + c: final pair of channel c
	logic [NS-1:0]     mask_q;
	logic [BYTE_W-1:0] len_q  [NS];
	logic [BYTE_W-1:0] byte_q [NS];

	logic [NS-1:0]     sel_oh;
	logic [IDX_W-1:0]  sel_idx;
	logic              only_one;
	logic              pop;
	logic [NS-1:0]     new_mask;

	always_comb begin
		sel_oh  = '0;
		sel_idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel_oh      = '0;
				sel_oh[i]   = 1'b1;
				sel_idx     = IDX_W'(i);
			end
		end
	end

	assign only_one  = (mask_q & (mask_q - NS'(1))) == '0;
	assign out_valid = |mask_q;
	assign pop       = out_valid && out_ready;
	assign in_ready  = !out_valid || (pop && only_one);

	always_comb begin
		out_pair.run_length   = len_q[sel_idx];
		out_pair.run_byte     = byte_q[sel_idx];
		out_pair.final_run    = (32'(sel_idx) >= NUM_CHANNELS);
		out_pair.channel      = (32'(sel_idx) >= NUM_CHANNELS) ?
			CHAN_W'(32'(sel_idx) - NUM_CHANNELS) : CHAN_W'(sel_idx);
		out_pair.last_of_item = only_one;
	end

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			new_mask[c]                = lanes[c].brk_valid;
			new_mask[NUM_CHANNELS + c] = last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (accept) begin
			mask_q <= new_mask;
		end else if (pop) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				len_q[c]                 <= lanes[c].brk_len;
				byte_q[c]                <= lanes[c].brk_byte;
				len_q[NUM_CHANNELS + c]  <= lanes[c].fin_len;
				byte_q[NUM_CHANNELS + c] <= lanes[c].fin_byte;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/rgb_channel_rle_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RGB run-length encoder.
// pix_in: one pixel beat per item (red, green, blue, last_pixel), raster order.
// pair_out: one (channel, run_length, run_byte) pair per beat; pairs closed by a
//   pixel come first in channel order, then on last_pixel the final run of each
//   channel. last_of_item marks the last pair caused by a pixel.
// APB: register 0 at address 0 is max_run (reset 255); write it while idle.
// Timing: the pairs of a pixel are registered on acceptance and the first is on
//   pair_out in the cycle after the pixel beat. A pixel produces k pairs, k from 0
//   to 2*NUM_CHANNELS; the single pair output drains one pair per cycle while
//   pair_out.ready is high, and a new pixel is taken in the cycle its last pair
//   leaves.
// Reset clears all runs and pending pairs; no run is open afterwards.
// When the receiver stalls, the current pair holds and pix_in stops once the
//   pixel's remaining pairs cannot drain.
module rgb_channel_rle_encoder_unit import rcre_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rcre_pixel_if.sink             pix_in,
	rcre_pair_if.source            pair_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);
	logic [BYTE_W-1:0] max_run_q;
	logic              run_open_q;
	logic              accept;
	logic              in_ready;
	logic [BYTE_W-1:0] lane_byte [NUM_CHANNELS];
	lane_pairs_t       lanes     [NUM_CHANNELS];

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_RUN) ? APB_DW'(max_run_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_run_q <= MAX_RUN_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_RUN)) begin
			max_run_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign pix_in.ready = in_ready;
	assign accept       = pix_in.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
		end else if (accept) begin
			run_open_q <= !pix_in.data.last_pixel;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			case (c)
				0:       lane_byte[c] = pix_in.data.red;
				1:       lane_byte[c] = pix_in.data.green;
				2:       lane_byte[c] = pix_in.data.blue;
				default: lane_byte[c] = '0;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
		rcre_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.pixel_byte (lane_byte[g]),
			.last_pixel (pix_in.data.last_pixel),
			.run_open   (run_open_q),
			.max_run    (max_run_q),
			.pairs      (lanes[g])
		);
	end

	rcre_merge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.last_pixel (pix_in.data.last_pixel),
		.lanes      (lanes),
		.in_ready   (in_ready),
		.out_valid  (pair_out.valid),
		.out_ready  (pair_out.ready),
		.out_pair   (pair_out.data)
	);

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		pair_out.valid |-> (32'(pair_out.data.channel) < NUM_CHANNELS))
		else $error("pair channel out of range");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pair_out.valid |-> (pair_out.data.run_length != '0))
		else $error("zero-length run emitted");

	a_no_overtake: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && pair_out.valid) |-> (pair_out.data.last_of_item && pair_out.ready))
		else $error("new pixel taken while pairs still pending");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pix_in.data.last_pixel) |=> (!run_open_q && pair_out.valid))
		else $error("frame end did not close runs");
endmodule
`default_nettype wire
